/* sv/modbus_response_receiver_assert.svh */
// assertion macros for the modbus response receiver
// included by the modules that check their own logic; no other dependencies
`ifndef MODBUS_RESPONSE_RECEIVER_ASSERT_SVH
`define MODBUS_RESPONSE_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS
// checked while reset is low
`define MRR_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
// checked at every edge, reset included
`define MRR_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define MRR_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define MRR_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif

`endif

/* sv/mrr_pkg.sv */
// types, codes and the crc-16/modbus byte update for the modbus response receiver
// no dependencies
`default_nettype none

package mrr_pkg;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_BYTE  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EXCEPTION = 2'd1;
  localparam logic [1:0] STATUS_SHORT     = 2'd2;
  localparam logic [1:0] STATUS_CRC_ERR   = 2'd3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] TIMEOUT_RESET   = 8'd10;
  localparam logic [7:0] MIN_FRAME_LEN   = 8'd7;
  localparam logic [7:0] FRAME_OVERHEAD  = 8'd5;
  localparam logic [7:0] EXC_FRAME_LEN   = 8'd3;
  localparam logic [7:0] FUNC_BYTE_POS   = 8'd1;
  localparam logic [7:0] EXC_CODE_ZERO   = 8'd3;
  localparam logic [7:0] IDLE_MAX        = 8'd255;
  localparam int         FUNC_EXC_BIT    = 7;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic [7:0] expected_address;
    logic [6:0] reg_count;
  } in_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_index;
    logic [7:0] byte_value;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] exception_code;
    logic [7:0] frame_length;
  } out_item_t;

  // one byte through the reflected crc, bit by bit
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/mrr_rx_if.sv */
// input channel of the modbus response receiver: valid/ready and the item fields
// no dependencies
`default_nettype none

interface mrr_rx_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  logic [7:0] expected_address;
  logic [6:0] reg_count;

  modport source (
    output valid, mode, data_byte, expected_address, reg_count,
    input  ready
  );
  modport sink (
    input  valid, mode, data_byte, expected_address, reg_count,
    output ready
  );
endinterface

`default_nettype wire

/* sv/mrr_res_if.sv */
// result channel of the modbus response receiver: valid/ready and the result fields
// no dependencies
`default_nettype none

interface mrr_res_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] byte_index;
  logic [7:0] byte_value;
  logic       done_res;
  logic [1:0] status;
  logic [7:0] exception_code;
  logic [7:0] frame_length;

  modport source (
    output valid, byte_valid, byte_index, byte_value, done_res, status,
           exception_code, frame_length,
    input  ready
  );
  modport sink (
    input  valid, byte_valid, byte_index, byte_value, done_res, status,
           exception_code, frame_length,
    output ready
  );
endinterface

`default_nettype wire

/* sv/mrr_in_reg.sv */
// input register stage: captures one word from the input channel
// depends on mrr_pkg
`default_nettype none

module mrr_in_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire mrr_pkg::in_item_t in_item,
  input  wire logic             take,
  output logic                  item_valid,
  output mrr_pkg::in_item_t     item
);

  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

/* sv/mrr_frame.sv */
// frame tracker: address match, byte count, running crc, idle timer, end status
// depends on mrr_pkg and modbus_response_receiver_assert.svh
`default_nettype none
`include "modbus_response_receiver_assert.svh"

module mrr_frame #(
  parameter int MAX_REGISTERS = 125
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire mrr_pkg::in_item_t item,
  input  wire logic [7:0]        timeout_ticks,
  output logic                   res_valid,
  output mrr_pkg::out_item_t     res
);

  localparam logic [6:0] REGS_MAX = 7'(MAX_REGISTERS);

  logic        receiving, receiving_next;
  logic [7:0]  frame_count, frame_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic        exception_flag, exception_flag_next;
  logic [7:0]  idle_count, idle_count_next;
  logic [7:0]  match_address, match_address_next;
  logic [7:0]  target_length, target_length_next;

  logic [6:0]  regs_sat;
  logic [15:0] crc_upd;
  logic [7:0]  count_inc;
  logic [7:0]  idle_inc;

  function automatic logic [1:0] end_status(input logic [7:0] cnt, input logic [15:0] crc);
    if (cnt < mrr_pkg::MIN_FRAME_LEN) begin
      return mrr_pkg::STATUS_SHORT;
    end
    return (crc == 16'h0000) ? mrr_pkg::STATUS_OK : mrr_pkg::STATUS_CRC_ERR;
  endfunction

  assign regs_sat  = (item.reg_count > REGS_MAX) ? REGS_MAX : item.reg_count;
  assign crc_upd   = mrr_pkg::crc_byte(running_crc, item.data_byte);
  assign count_inc = frame_count + 8'd1;
  assign idle_inc  = (idle_count == mrr_pkg::IDLE_MAX) ? idle_count : idle_count + 8'd1;

  always_comb begin
    receiving_next      = receiving;
    frame_count_next    = frame_count;
    running_crc_next    = running_crc;
    exception_flag_next = exception_flag;
    idle_count_next     = idle_count;
    match_address_next  = match_address;
    target_length_next  = target_length;
    res_valid           = 1'b0;
    res                 = '0;
    case (item.mode)
      mrr_pkg::MODE_START: begin
        receiving_next      = 1'b1;
        frame_count_next    = 8'd0;
        running_crc_next    = mrr_pkg::CRC_INIT;
        exception_flag_next = 1'b0;
        idle_count_next     = 8'd0;
        match_address_next  = item.expected_address;
        target_length_next  = {regs_sat, 1'b0} + mrr_pkg::FRAME_OVERHEAD;
      end
      mrr_pkg::MODE_BYTE: begin
        if (receiving) begin
          idle_count_next = 8'd0;
          // leading bytes are dropped until the address shows up
          if (frame_count != 8'd0 || item.data_byte == match_address) begin
            res_valid        = 1'b1;
            res.byte_valid   = 1'b1;
            res.byte_index   = frame_count;
            res.byte_value   = item.data_byte;
            running_crc_next = crc_upd;
            frame_count_next = count_inc;
            if (frame_count == mrr_pkg::FUNC_BYTE_POS) begin
              exception_flag_next = item.data_byte[mrr_pkg::FUNC_EXC_BIT];
            end
            if (count_inc == mrr_pkg::EXC_FRAME_LEN && exception_flag_next) begin
              res.done_res       = 1'b1;
              res.status         = mrr_pkg::STATUS_EXCEPTION;
              res.exception_code = (item.data_byte == 8'd0) ? mrr_pkg::EXC_CODE_ZERO
                                                            : item.data_byte;
              res.frame_length   = count_inc;
              receiving_next     = 1'b0;
            end else if (count_inc >= target_length) begin
              res.done_res     = 1'b1;
              res.status       = end_status(count_inc, crc_upd);
              res.frame_length = count_inc;
              receiving_next   = 1'b0;
            end
          end
        end
      end
      mrr_pkg::MODE_TICK: begin
        if (receiving) begin
          idle_count_next = idle_inc;
          // a timeout of zero closes on the first tick, same as one
          if (idle_inc >= timeout_ticks) begin
            res_valid        = 1'b1;
            res.done_res     = 1'b1;
            res.status       = end_status(frame_count, running_crc);
            res.frame_length = frame_count;
            receiving_next   = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving      <= 1'b0;
      frame_count    <= 8'd0;
      running_crc    <= mrr_pkg::CRC_INIT;
      exception_flag <= 1'b0;
      idle_count     <= 8'd0;
      match_address  <= 8'd0;
      target_length  <= 8'd0;
    end else if (step) begin
      receiving      <= receiving_next;
      frame_count    <= frame_count_next;
      running_crc    <= running_crc_next;
      exception_flag <= exception_flag_next;
      idle_count     <= idle_count_next;
      match_address  <= match_address_next;
      target_length  <= target_length_next;
    end
  end

  `MRR_ASSERT(a_done_closes, clk, rst,
    step && res_valid && res.done_res |=> !receiving,
    "frame end left receiver armed")
  `MRR_ASSERT(a_count_below_target, clk, rst,
    receiving |-> frame_count < target_length,
    "frame count passed target while receiving")
  `MRR_ASSERT(a_byte_clears_idle, clk, rst,
    step && receiving && item.mode == mrr_pkg::MODE_BYTE |=> idle_count == 8'd0,
    "idle count not cleared by byte")

endmodule

`default_nettype wire

/* sv/modbus_response_receiver.sv */
// Modbus RTU response receiver. One word is taken per clock cycle, back to
// back, while no result waits; each word goes through an input register, one
// pass of logic (a full byte of crc-16/modbus update plus the frame counters
// and compares) and a result register, which holds its result until taken.
// While a result waits untaken the input takes one more word into the empty
// input register and then stalls; the cycle the result is taken, both
// registers move on together. A start word arms the receiver with an address
// and register count; byte words are echoed once the address is seen, and the
// last byte, an exception reply or the idle tick timeout (cfg_wr_data on
// cfg_wr_en) closes the frame with its status.
// Depends on mrr_pkg, mrr_rx_if, mrr_res_if, mrr_in_reg, mrr_frame and
// modbus_response_receiver_assert.svh.
`default_nettype none
`include "modbus_response_receiver_assert.svh"

module modbus_response_receiver #(
  parameter int MAX_REGISTERS = 125
) (
  input  wire logic       clk,
  input  wire logic       rst,
  mrr_rx_if.sink          rx,
  mrr_res_if.source       res,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data
);

  logic [7:0]         timeout_reg;
  mrr_pkg::in_item_t  rx_item;
  mrr_pkg::in_item_t  item;
  logic               item_valid;
  logic               step;
  logic               core_valid;
  mrr_pkg::out_item_t core_res;
  logic               out_valid;
  mrr_pkg::out_item_t out_q;

  assign rx_item = '{mode:             rx.mode,
                     data_byte:        rx.data_byte,
                     expected_address: rx.expected_address,
                     reg_count:        rx.reg_count};

  // the word in the input register moves on once the result slot is free
  assign step = item_valid && (!out_valid || res.ready);

  mrr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rx.valid),
    .in_ready   (rx.ready),
    .in_item    (rx_item),
    .take       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  mrr_frame #(
    .MAX_REGISTERS (MAX_REGISTERS)
  ) u_frame (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .item          (item),
    .timeout_ticks (timeout_reg),
    .res_valid     (core_valid),
    .res           (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_reg <= mrr_pkg::TIMEOUT_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout_reg <= cfg_wr_data;
      end
      if (step && core_valid) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && core_valid) begin
      out_q <= core_res;
    end
  end

  assign res.valid          = out_valid;
  assign res.byte_valid     = out_q.byte_valid;
  assign res.byte_index     = out_q.byte_index;
  assign res.byte_value     = out_q.byte_value;
  assign res.done_res       = out_q.done_res;
  assign res.status         = out_q.status;
  assign res.exception_code = out_q.exception_code;
  assign res.frame_length   = out_q.frame_length;

  `MRR_ASSERT(a_ready_when_empty, clk, rst,
    !out_valid |-> rx.ready,
    "input stalled with empty result slot")
  `MRR_ASSERT(a_cfg_written, clk, rst,
    $past(cfg_wr_en) && !$past(rst) |-> timeout_reg == $past(cfg_wr_data),
    "timeout register missed a write")
  `MRR_ASSERT(a_res_held, clk, rst,
    out_valid && !res.ready |=> out_valid && $stable(out_q),
    "waiting result word changed")

endmodule

`default_nettype wire

/* sim/tb_modbus_response_receiver.sv */
// testbench for modbus_response_receiver: random and directed rtu response frames,
// results checked against an in-bench prediction of the receiver
// depends on mrr_pkg, mrr_rx_if, mrr_res_if and the receiver rtl
`timescale 1ns / 1ps

module tb_modbus_response_receiver;

  localparam logic [1:0] MODE_UNUSED   = 2'd3;
  localparam logic [6:0] REG_CAP       = 7'd125;
  localparam int         PIPE_SETTLE   = 8;
  localparam int         LIMIT_CYCLES  = 1000000;
  localparam int         PHASE_WORDS   = 160;
  localparam int         PHASE_COUNT   = 8;

  typedef enum int {
    FR_GOOD, FR_BAD_CRC, FR_EXCEPTION, FR_TRUNCATED, FR_ABORTED
  } frame_kind_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  mrr_rx_if  rx_ch ();
  mrr_res_if res_ch ();

  modbus_response_receiver u_dut (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx_ch),
    .res         (res_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // receiver state as the bench sees it
  logic        rcv_active  = 1'b0;
  logic [7:0]  rcv_count   = 8'd0;
  logic [15:0] rcv_crc     = mrr_pkg::CRC_INIT;
  logic        rcv_exc     = 1'b0;
  logic [7:0]  rcv_idle    = 8'd0;
  logic [7:0]  rcv_addr    = 8'd0;
  logic [7:0]  rcv_target  = 8'd0;
  logic [7:0]  timeout_now = mrr_pkg::TIMEOUT_RESET;

  mrr_pkg::in_item_t  pending_words[$];
  mrr_pkg::out_item_t awaited_echoes[$];
  int        words_queued   = 0;
  int        words_accepted = 0;
  int        fail_count     = 0;
  int        cycle_count    = 0;
  int        gen_timeout    = mrr_pkg::TIMEOUT_RESET;

  bit        word_loaded = 1'b0;
  int        rx_gap      = 0;
  int        res_stall   = 0;
  bit        rx_steady   = 1'b0;
  bit        res_steady  = 1'b0;
  mrr_pkg::in_item_t  seen_word;
  mrr_pkg::in_item_t  next_word;
  mrr_pkg::out_item_t echo_pred;
  mrr_pkg::out_item_t echo_want;

  function automatic logic [15:0] crc16_fold(logic [15:0] acc, logic [7:0] b);
    logic [15:0] x;
    x = acc ^ {8'h00, b};
    repeat (8) x = {1'b0, x[15:1]} ^ (x[0] ? mrr_pkg::CRC_POLY : 16'h0000);
    return x;
  endfunction

  function automatic void close_frame(inout mrr_pkg::out_item_t r);
    r.done_res     = 1'b1;
    r.frame_length = rcv_count;
    if (rcv_count < mrr_pkg::MIN_FRAME_LEN) r.status = mrr_pkg::STATUS_SHORT;
    else r.status = (rcv_crc == 16'h0000) ? mrr_pkg::STATUS_OK : mrr_pkg::STATUS_CRC_ERR;
    rcv_active = 1'b0;
  endfunction

  // returns 1 when the word produces a result word
  function automatic bit predict_echo_word(input mrr_pkg::in_item_t w,
                                           output mrr_pkg::out_item_t r);
    logic [6:0] regs;
    r = '0;
    case (w.mode)
      mrr_pkg::MODE_START: begin
        regs       = (w.reg_count > REG_CAP) ? REG_CAP : w.reg_count;
        rcv_active = 1'b1;
        rcv_count  = 8'd0;
        rcv_crc    = mrr_pkg::CRC_INIT;
        rcv_exc    = 1'b0;
        rcv_idle   = 8'd0;
        rcv_addr   = w.expected_address;
        rcv_target = {1'b0, regs} * 8'd2 + mrr_pkg::FRAME_OVERHEAD;
        return 1'b0;
      end
      mrr_pkg::MODE_BYTE: begin
        if (!rcv_active) return 1'b0;
        rcv_idle = 8'd0;
        // hunting for the address byte
        if (rcv_count == 8'd0 && w.data_byte != rcv_addr) return 1'b0;
        r.byte_valid = 1'b1;
        r.byte_index = rcv_count;
        r.byte_value = w.data_byte;
        rcv_crc = crc16_fold(rcv_crc, w.data_byte);
        if (rcv_count == mrr_pkg::FUNC_BYTE_POS) rcv_exc = w.data_byte[mrr_pkg::FUNC_EXC_BIT];
        rcv_count = rcv_count + 8'd1;
        if (rcv_count == mrr_pkg::EXC_FRAME_LEN && rcv_exc) begin
          r.done_res       = 1'b1;
          r.status         = mrr_pkg::STATUS_EXCEPTION;
          r.exception_code = (w.data_byte == 8'd0) ? mrr_pkg::EXC_CODE_ZERO : w.data_byte;
          r.frame_length   = rcv_count;
          rcv_active       = 1'b0;
        end else if (rcv_count >= rcv_target) begin
          close_frame(r);
        end
        return 1'b1;
      end
      mrr_pkg::MODE_TICK: begin
        if (!rcv_active) return 1'b0;
        if (rcv_idle != mrr_pkg::IDLE_MAX) rcv_idle = rcv_idle + 8'd1;
        if (rcv_idle < timeout_now) return 1'b0;
        close_frame(r);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int draw_gap(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 9);
    return $urandom_range(10, 40);
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // input word driver
  always @(negedge clk) begin
    if (!rst && !word_loaded) begin
      if (rx_gap > 0) begin
        rx_gap--;
        rx_ch.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        next_word = pending_words.pop_front();
        rx_ch.mode             <= next_word.mode;
        rx_ch.data_byte        <= next_word.data_byte;
        rx_ch.expected_address <= next_word.expected_address;
        rx_ch.reg_count        <= next_word.reg_count;
        rx_ch.valid            <= 1'b1;
        word_loaded = 1'b1;
        if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
        rx_gap = draw_gap(rx_steady);
      end else begin
        rx_ch.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (!rst) begin
      if (res_stall > 0) begin
        res_stall--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if ($urandom_range(0, 63) == 0) res_steady = !res_steady;
        res_stall = draw_gap(res_steady);
      end
    end
  end

  // monitor: accepted words feed the prediction, result words are checked
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end else if (!rst) begin
      if (cfg_wr_en) timeout_now = cfg_wr_data;
      if (rx_ch.valid && rx_ch.ready) begin
        word_loaded = 1'b0;
        words_accepted++;
        seen_word.mode             = rx_ch.mode;
        seen_word.data_byte        = rx_ch.data_byte;
        seen_word.expected_address = rx_ch.expected_address;
        seen_word.reg_count        = rx_ch.reg_count;
        if (predict_echo_word(seen_word, echo_pred)) awaited_echoes.push_back(echo_pred);
      end
      if (res_ch.valid && res_ch.ready) begin
        if (awaited_echoes.size() == 0) begin
          $error("result word with no expectation waiting");
          fail_count++;
        end else begin
          echo_want = awaited_echoes.pop_front();
          check_field("byte_valid", echo_want.byte_valid, res_ch.byte_valid);
          check_field("byte_index", echo_want.byte_index, res_ch.byte_index);
          check_field("byte_value", echo_want.byte_value, res_ch.byte_value);
          check_field("done_res", echo_want.done_res, res_ch.done_res);
          check_field("status", echo_want.status, res_ch.status);
          check_field("exception_code", echo_want.exception_code, res_ch.exception_code);
          check_field("frame_length", echo_want.frame_length, res_ch.frame_length);
        end
      end
    end
  end

  task automatic queue_word(logic [1:0] m, logic [7:0] d, logic [7:0] a, logic [6:0] n);
    mrr_pkg::in_item_t w;
    w.mode             = m;
    w.data_byte        = d;
    w.expected_address = a;
    w.reg_count        = n;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic send_start(logic [7:0] addr, logic [6:0] regs);
    queue_word(mrr_pkg::MODE_START, 8'($urandom), addr, regs);
  endtask

  task automatic send_byte(logic [7:0] d);
    queue_word(mrr_pkg::MODE_BYTE, d, 8'($urandom), 7'($urandom));
  endtask

  task automatic send_tick();
    queue_word(mrr_pkg::MODE_TICK, 8'($urandom), 8'($urandom), 7'($urandom));
  endtask

  // ticks that stay short of the idle timeout
  task automatic idle_ticks_below_timeout();
    int span;
    int n;
    span = (gen_timeout == 0) ? 1 : gen_timeout;
    if (span > 1 && $urandom_range(0, 3) == 0) begin
      if (span <= 16 && $urandom_range(0, 3) == 0) n = span - 1;
      else n = $urandom_range(1, (span - 1 < 3) ? span - 1 : 3);
      repeat (n) send_tick();
    end
  endtask

  task automatic send_frame(frame_kind_t kind, logic [7:0] addr, logic [6:0] regs_field);
    logic [7:0]  body[$];
    logic [15:0] c;
    int          nregs;
    int          cut;
    int          pos;
    nregs = (regs_field > REG_CAP) ? REG_CAP : regs_field;
    send_start(addr, regs_field);
    body.push_back(addr);
    if (kind == FR_EXCEPTION) begin
      body.push_back(8'h80 | 8'($urandom_range(0, 127)));
      body.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
    end else begin
      body.push_back(8'($urandom_range(0, 127)));
      body.push_back(8'(nregs * 2));
      repeat (nregs * 2) body.push_back(8'($urandom));
    end
    c = mrr_pkg::CRC_INIT;
    foreach (body[i]) c = crc16_fold(c, body[i]);
    body.push_back(c[7:0]);
    body.push_back(c[15:8]);
    if (kind == FR_BAD_CRC) begin
      pos = $urandom_range(2, body.size() - 1);
      body[pos] = body[pos] ^ 8'($urandom_range(1, 255));
    end
    cut = body.size();
    if (kind == FR_TRUNCATED || kind == FR_ABORTED) cut = $urandom_range(0, body.size() - 1);
    // line noise ahead of the address
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        idle_ticks_below_timeout();
        send_byte(addr ^ 8'($urandom_range(1, 255)));
      end
    end
    for (int i = 0; i < cut; i++) begin
      idle_ticks_below_timeout();
      send_byte(body[i]);
    end
    if (kind == FR_TRUNCATED)
      repeat (((gen_timeout == 0) ? 1 : gen_timeout) + $urandom_range(0, 2)) send_tick();
  endtask

  task automatic wait_quiet();
    do @(negedge clk); while (words_accepted != words_queued || awaited_echoes.size() != 0);
    repeat (PIPE_SETTLE) @(negedge clk);
  endtask

  task automatic write_timeout(logic [7:0] v);
    wait_quiet();
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    gen_timeout = v;
  endtask

  task automatic random_frames(int phase_end);
    frame_kind_t kind;
    logic [6:0]  regs;
    int          r;
    while (words_queued < phase_end) begin
      r = $urandom_range(0, 99);
      if (r < 45) kind = FR_GOOD;
      else if (r < 60) kind = FR_BAD_CRC;
      else if (r < 75) kind = FR_EXCEPTION;
      else if (r < 90) kind = FR_TRUNCATED;
      else kind = FR_ABORTED;
      // a long timeout costs many tick words, keep those frames rare
      if (kind == FR_TRUNCATED && gen_timeout > 16 && $urandom_range(0, 7) != 0)
        kind = FR_GOOD;
      r = $urandom_range(0, 99);
      if (r == 0) regs = 7'($urandom_range(100, 127));
      else if (r < 5) regs = 7'd0;
      else regs = 7'($urandom_range(1, 6));
      send_frame(kind, 8'($urandom), regs);
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          r = $urandom_range(0, 2);
          if (r == 0) queue_word(MODE_UNUSED, 8'($urandom), 8'($urandom), 7'($urandom));
          else if (r == 1) send_byte(8'($urandom));
          else send_tick();
        end
      end
    end
  endtask

  initial begin
    rst                    = 1'b1;
    cfg_wr_en              = 1'b0;
    cfg_wr_data            = 8'd0;
    rx_ch.valid            = 1'b0;
    rx_ch.mode             = mrr_pkg::MODE_TICK;
    rx_ch.data_byte        = 8'd0;
    rx_ch.expected_address = 8'd0;
    rx_ch.reg_count        = 7'd0;
    res_ch.ready           = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // idle receiver ignores bytes, ticks and the unused mode
    send_byte(8'hFF);
    send_tick();
    queue_word(MODE_UNUSED, 8'hFF, 8'hFF, 7'h7F);
    // zero registers: five bytes then not enough data
    send_start(8'hFF, 7'd0);
    send_byte(8'hFF);
    send_byte(8'h03);
    send_byte(8'h00);
    send_byte(8'h50);
    send_byte(8'h40);
    // dropped leading byte, exception reply carrying code zero
    send_start(8'h00, 7'd1);
    send_byte(8'h55);
    send_byte(8'h00);
    send_byte(8'h83);
    send_byte(8'h00);
    // oversized count, then a restart in the middle of the frame
    send_start(8'h11, 7'd127);
    send_byte(8'h11);
    send_byte(8'h03);
    send_frame(FR_GOOD, 8'h22, 7'd1);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: write_timeout(8'd1);
        1: write_timeout(8'd255);
        2: write_timeout(8'd0);
        default: write_timeout((p % 2) ? 8'($urandom_range(2, 8)) : 8'($urandom_range(1, 255)));
      endcase
      random_frames(words_queued + PHASE_WORDS);
    end

    wait_quiet();
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
